// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the stencil CSR RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, disabled while reset is active
`define SCPB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define SCPB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  `SCPB_ASSERT(name, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- rtl/core/scpb_pkg.sv -----
// ----------------------------------------------------------------------------
// scpb_pkg
// Types, widths and codes of the five-point stencil CSR pattern builder.
// ----------------------------------------------------------------------------
package scpb_pkg;

  localparam int ColW     = 10;
  localparam int RowW     = 10;
  localparam int TypeW    = 16;
  localparam int LinW     = 20;
  localparam int CntW     = 23;
  localparam int CfgW     = 11;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 3;
  localparam int NumDir   = 5;
  localparam int QDepth   = 2;

  typedef enum logic [2:0] {
    DIR_S = 3'd0,
    DIR_W = 3'd1,
    DIR_C = 3'd2,
    DIR_E = 3'd3,
    DIR_N = 3'd4
  } dir_e;

  // entry ordering of a cell
  typedef enum logic [1:0] {
    ORD_NORM       = 2'd0,
    ORD_WRAP_FIRST = 2'd1,
    ORD_WRAP_LAST  = 2'd2
  } ord_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_WIDTH  = 3'd0,
    CFG_ACTIVE_HEIGHT = 3'd1,
    CFG_FULL_WIDTH    = 3'd2,
    CFG_PERIODIC      = 3'd3,
    CFG_SOLID_MASK    = 3'd4,
    CFG_BOUNDARY_MASK = 3'd5,
    CFG_FLUID_MASK    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0]  active_width;
    logic [CfgW-1:0]  active_height;
    logic [CfgW-1:0]  full_width;
    logic             periodic;
    logic [TypeW-1:0] solid_mask;
    logic [TypeW-1:0] boundary_mask;
    logic [TypeW-1:0] fluid_mask;
  } cfg_t;

  // classified cell, one queue entry
  typedef struct packed {
    logic              first_cell;
    logic [NumDir-1:0] dir_mask;   // bit per dir_e code
    ord_e              ord;
    logic [LinW-1:0]   row_base;   // row * full_width
    logic [ColW-1:0]   col;
    logic [ColW-1:0]   east_col;
    logic [ColW-1:0]   west_col;
  } q_entry_t;

  function automatic dir_e slot_dir(ord_e ord, logic [2:0] slot);
    dir_e d;
    d = DIR_N;
    case (ord)
      ORD_WRAP_FIRST: begin
        case (slot)
          3'd0:    d = DIR_S;
          3'd1:    d = DIR_C;
          3'd2:    d = DIR_E;
          3'd3:    d = DIR_W;
          default: d = DIR_N;
        endcase
      end
      ORD_WRAP_LAST: begin
        case (slot)
          3'd0:    d = DIR_S;
          3'd1:    d = DIR_E;
          3'd2:    d = DIR_W;
          3'd3:    d = DIR_C;
          default: d = DIR_N;
        endcase
      end
      default: begin
        case (slot)
          3'd0:    d = DIR_S;
          3'd1:    d = DIR_W;
          3'd2:    d = DIR_C;
          3'd3:    d = DIR_E;
          default: d = DIR_N;
        endcase
      end
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/core/scpb_intf.sv -----
// ----------------------------------------------------------------------------
// scpb channel interfaces
// Valid/ready channels for grid cells in and CSR entries out.
// ----------------------------------------------------------------------------
interface scpb_cell_if import scpb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             first_cell;
  logic [ColW-1:0]  col;
  logic [RowW-1:0]  row;
  logic [TypeW-1:0] center_type;
  logic [TypeW-1:0] south_type;
  logic [TypeW-1:0] west_type;
  logic [TypeW-1:0] east_type;
  logic [TypeW-1:0] north_type;

  modport source (
    output valid, first_cell, col, row, center_type, south_type, west_type,
           east_type, north_type,
    input  ready
  );
  modport sink (
    input  valid, first_cell, col, row, center_type, south_type, west_type,
           east_type, north_type,
    output ready
  );
endinterface

interface scpb_entry_if import scpb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            entry_valid;
  logic [2:0]      direction;
  logic [LinW-1:0] row_index;
  logic [LinW-1:0] col_index;
  logic [CntW-1:0] entry_index;
  logic [CntW-1:0] row_end_pointer;
  logic            last;

  modport source (
    output valid, entry_valid, direction, row_index, col_index, entry_index,
           row_end_pointer, last,
    input  ready
  );
  modport sink (
    input  valid, entry_valid, direction, row_index, col_index, entry_index,
           row_end_pointer, last,
    output ready
  );
endinterface

// ----- rtl/core/scpb_front.sv -----
// ----------------------------------------------------------------------------
// scpb_front
// Accepts cells, classifies them into a neighbor mask and entry order.
// ----------------------------------------------------------------------------
module scpb_front import scpb_pkg::*; (
  scpb_cell_if.sink cell_i,
  input  cfg_t      cfg_i,
  input  logic      q_full_i,
  output logic      push_o,
  output q_entry_t  entry_o
);

  logic [CfgW-1:0]  col_x;
  logic [CfgW-1:0]  col_p1;
  logic [CfgW-1:0]  row_p1;
  logic [CfgW-1:0]  west_x;
  logic [TypeW-1:0] acc;
  logic             in_rng;
  logic             solid;
  logic             cb;
  logic             per;
  logic             at_last;
  logic [NumDir-1:0] dmask;

  assign cell_i.ready = !q_full_i;
  assign push_o       = cell_i.valid && !q_full_i;

  assign col_x   = {1'b0, cell_i.col};
  assign col_p1  = col_x + CfgW'(1);
  assign row_p1  = {1'b0, cell_i.row} + CfgW'(1);
  assign west_x  = cfg_i.active_width - CfgW'(1);
  assign acc     = cfg_i.boundary_mask | cfg_i.fluid_mask;
  assign in_rng  = (col_x < cfg_i.active_width) &&
                   ({1'b0, cell_i.row} < cfg_i.active_height);
  assign solid   = |(cell_i.center_type & cfg_i.solid_mask);
  assign cb      = |(cell_i.center_type & cfg_i.boundary_mask);
  assign per     = cfg_i.periodic;
  assign at_last = (col_p1 == cfg_i.active_width);

  always_comb begin
    dmask = '0;
    if (in_rng) begin
      if (solid) begin
        dmask[DIR_C] = cb;
      end else begin
        dmask[DIR_C] = 1'b1;
        dmask[DIR_S] = !cb && (cell_i.row != '0) && |(cell_i.south_type & acc);
        dmask[DIR_N] = !cb && (row_p1 < cfg_i.active_height) &&
                       |(cell_i.north_type & acc);
        dmask[DIR_W] = !cb && (per || cell_i.col != '0) &&
                       |(cell_i.west_type & acc);
        dmask[DIR_E] = !cb && (per || col_p1 < cfg_i.active_width) &&
                       |(cell_i.east_type & acc);
      end
    end
  end

  always_comb begin
    entry_o.first_cell = cell_i.first_cell;
    entry_o.dir_mask   = dmask;
    if (per && cell_i.col == '0) begin
      entry_o.ord = ORD_WRAP_FIRST;
    end else if (per && at_last) begin
      entry_o.ord = ORD_WRAP_LAST;
    end else begin
      entry_o.ord = ORD_NORM;
    end
    entry_o.row_base = {{(LinW-RowW){1'b0}}, cell_i.row} *
                       {{(LinW-CfgW){1'b0}}, cfg_i.full_width};
    entry_o.col      = cell_i.col;
    entry_o.east_col = at_last ? '0 : col_p1[ColW-1:0];
    entry_o.west_col = (cell_i.col == '0) ? west_x[ColW-1:0] : col_x[ColW-1:0] - ColW'(1);
  end

endmodule

// ----- rtl/core/scpb_queue.sv -----
// ----------------------------------------------------------------------------
// scpb_queue
// Short FIFO of classified cells between front and back.
// ----------------------------------------------------------------------------
module scpb_queue import scpb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     head_valid_o,
  output q_entry_t head_o
);

  localparam int PtrW = $clog2(QDepth);

  q_entry_t          mem_q [QDepth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o       = (cnt_q == (PtrW+1)'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QDepth-1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QDepth-1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/core/scpb_back.sv -----
// ----------------------------------------------------------------------------
// scpb_back
// Walks the queue head cell, numbers its nonzeros, drives the result register.
// ----------------------------------------------------------------------------
module scpb_back import scpb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  q_entry_t        head_i,
  input  logic [CfgW-1:0] full_width_i,
  output logic            pop_o,
  scpb_entry_if.source    entry_o
);

  logic [NumDir-1:0] done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ov_q, ov_d;
  logic [NumDir-1:0] rem;
  logic              empty;
  logic              fire;
  logic              last;
  logic              found;
  dir_e              sel;
  dir_e              d;
  logic [CntW-1:0]   ent;
  logic [CntW-1:0]   row_end;
  logic [LinW-1:0]   fw_x;
  logic [LinW-1:0]   row_idx;
  logic [LinW-1:0]   col_idx;

  assign rem     = head_i.dir_mask & ~done_q;
  assign empty   = (head_i.dir_mask == '0);
  assign fire    = head_valid_i && (!ov_q || entry_o.ready);
  assign last    = empty || ($countones(rem) == 1);
  assign ent     = (head_i.first_cell && done_q == '0) ? '0 : cnt_q;
  assign row_end = ent + CntW'($countones(rem));
  assign fw_x    = {{(LinW-CfgW){1'b0}}, full_width_i};
  assign row_idx = head_i.row_base + {{(LinW-ColW){1'b0}}, head_i.col};
  assign pop_o   = fire && last;

  // first pending direction in this cell's order
  always_comb begin
    found = 1'b0;
    sel   = DIR_C;
    for (int k = 0; k < NumDir; k++) begin
      d = slot_dir(head_i.ord, 3'(k));
      if (!found && rem[d]) begin
        sel   = d;
        found = 1'b1;
      end
    end
  end

  always_comb begin
    case (sel)
      DIR_S:   col_idx = row_idx - fw_x;
      DIR_W:   col_idx = head_i.row_base + {{(LinW-ColW){1'b0}}, head_i.west_col};
      DIR_E:   col_idx = head_i.row_base + {{(LinW-ColW){1'b0}}, head_i.east_col};
      DIR_N:   col_idx = row_idx + fw_x;
      default: col_idx = row_idx;
    endcase
  end

  always_comb begin
    done_d = done_q;
    cnt_d  = cnt_q;
    ov_d   = entry_o.ready ? 1'b0 : ov_q;
    if (fire) begin
      ov_d   = 1'b1;
      cnt_d  = empty ? ent : ent + CntW'(1);
      done_d = last ? '0 : (done_q | (NumDir'(1) << sel));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      done_q <= done_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      entry_o.entry_valid     <= !empty;
      entry_o.direction       <= empty ? 3'(DIR_S) : 3'(sel);
      entry_o.row_index       <= row_idx;
      entry_o.col_index       <= empty ? '0 : col_idx;
      entry_o.entry_index     <= empty ? '0 : ent;
      entry_o.row_end_pointer <= row_end;
      entry_o.last            <= last;
    end
  end

  assign entry_o.valid = ov_q;

endmodule

// ----- rtl/core/stencil_csr_pattern_builder.sv -----
// A cell accepted into the queue has its first result registered from the queue
//   head into the result register, where the receiver can then take it.
// Throughput: one cell per cycle into the queue while it is not full; results
//   leave one per cycle while the receiver keeps up, max(k,1) per cell with
//   k its nonzero count (0..5). The rate is set by the single result register.
// Reset: registers to defaults (sizes 1024, masks 0, not periodic), counter 0,
//   queue empty. No clearing pass.
// ----------------------------------------------------------------------------
// stencil_csr_pattern_builder
// Five-point stencil CSR sparsity pattern builder, decoupled front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stencil_csr_pattern_builder import scpb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int TYPE_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  scpb_cell_if.sink           cell_i,
  scpb_entry_if.source        entry_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // type bits beyond TYPE_BITS never match
  localparam logic [TypeW-1:0] TypeMask =
    (TYPE_BITS >= TypeW) ? {TypeW{1'b1}} : TypeW'((64'd1 << TYPE_BITS) - 64'd1);

  cfg_t            cfg_q, cfg_d;
  logic [CfgW-1:0] wr_val;
  logic            push;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  q_entry_t        front_entry;
  q_entry_t        head;

  assign wr_val = cfg_wdata_i[CfgW-1:0];

  // config writes, size registers saturate at the configured maxima
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE_WIDTH:
          cfg_d.active_width = (32'(wr_val) > MAX_WIDTH) ? CfgW'(MAX_WIDTH) : wr_val;
        CFG_ACTIVE_HEIGHT:
          cfg_d.active_height = (32'(wr_val) > MAX_HEIGHT) ? CfgW'(MAX_HEIGHT) : wr_val;
        CFG_FULL_WIDTH:
          cfg_d.full_width = (32'(wr_val) > MAX_WIDTH) ? CfgW'(MAX_WIDTH) : wr_val;
        CFG_PERIODIC:      cfg_d.periodic      = cfg_wdata_i[0];
        CFG_SOLID_MASK:    cfg_d.solid_mask    = cfg_wdata_i[TypeW-1:0] & TypeMask;
        CFG_BOUNDARY_MASK: cfg_d.boundary_mask = cfg_wdata_i[TypeW-1:0] & TypeMask;
        CFG_FLUID_MASK:    cfg_d.fluid_mask    = cfg_wdata_i[TypeW-1:0] & TypeMask;
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_width  <= CfgW'(1024);
      cfg_q.active_height <= CfgW'(1024);
      cfg_q.full_width    <= CfgW'(1024);
      cfg_q.periodic      <= 1'b0;
      cfg_q.solid_mask    <= '0;
      cfg_q.boundary_mask <= '0;
      cfg_q.fluid_mask    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: classify the incoming cell, form row * full_width
  scpb_front u_front (
    .cell_i   (cell_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (front_entry)
  );

  // decoupling queue
  scpb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (front_entry),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: one nonzero per cycle from the head cell while results are taken, running entry counter
  scpb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .full_width_i (cfg_q.full_width),
    .pop_o        (pop),
    .entry_o      (entry_o)
  );

  // a result that is not the cell's last is always a real nonzero
  `SCPB_ASSERT_IMP(a_nonlast_is_entry, clk_i, rst_ni, entry_o.valid && !entry_o.last, entry_o.entry_valid, "non-last result without entry")
  // an empty-cell result carries zero direction, column and index
  `SCPB_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, entry_o.valid && !entry_o.entry_valid, entry_o.direction == 3'd0 && entry_o.col_index == '0 && entry_o.entry_index == '0, "empty result fields not zero")
  // row end lies one to five entries past any nonzero of the cell
  `SCPB_ASSERT_IMP(a_row_end_span, clk_i, rst_ni, entry_o.valid && entry_o.entry_valid, CntW'(entry_o.row_end_pointer - entry_o.entry_index) >= CntW'(1) && CntW'(entry_o.row_end_pointer - entry_o.entry_index) <= CntW'(NumDir), "row end pointer out of span")

endmodule

// ----- tb/sv/stencil_csr_pattern_builder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stencil_csr_pattern_builder_tb
// Self-checking bench for the five-point stencil CSR pattern builder. A
// queue-fed driver sends grid cell requests and a monitor checks every CSR
// entry against an in-bench predictor of the sparsity pattern. A short
// directed part covers grid edges, node classes, periodic wrap, zero active
// size and register saturation. A random part follows, run under random
// register settings, with stalls on both channels but in the last phase.
// ----------------------------------------------------------------------------
module stencil_csr_pattern_builder_tb;
  import scpb_pkg::*;

  localparam int          ClkHalf      = 5;
  localparam int          ResetCycles  = 6;
  localparam int          SettleCycles = 4;      // settle wait once all entries are out
  localparam int          CycleLimit   = 200000;
  localparam int          MaxReports   = 100;
  localparam int          RandPhases   = 8;
  localparam int          PhaseCells   = 30;
  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned MaxHeight    = 1024;

  // index past the register list, the block must ignore it
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd7;

  // node type codes for the directed part (masks set to match)
  localparam logic [TypeW-1:0] TySolid    = 16'h0001;
  localparam logic [TypeW-1:0] TyBnd      = 16'h0002;
  localparam logic [TypeW-1:0] TySolidBnd = 16'h0003;
  localparam logic [TypeW-1:0] TyFluid    = 16'h0004;
  localparam logic [TypeW-1:0] TyAll      = 16'hFFFF;

  typedef struct packed {
    logic             first_cell;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic [TypeW-1:0] center_type;
    logic [TypeW-1:0] south_type;
    logic [TypeW-1:0] west_type;
    logic [TypeW-1:0] east_type;
    logic [TypeW-1:0] north_type;
  } cell_req_t;

  typedef struct packed {
    logic            entry_valid;
    dir_e            direction;
    logic [LinW-1:0] row_index;
    logic [LinW-1:0] col_index;
    logic [CntW-1:0] entry_index;
    logic [CntW-1:0] row_end_pointer;
    logic            last;
  } row_entry_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // driven values, held in initialized variables so every input is known at time 0
  logic                drv_valid = 1'b0;
  cell_req_t           cell_drv  = '0;
  logic                rcv_ready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  scpb_cell_if  cell_if ();
  scpb_entry_if entry_if ();

  assign cell_if.valid       = drv_valid;
  assign cell_if.first_cell  = cell_drv.first_cell;
  assign cell_if.col         = cell_drv.col;
  assign cell_if.row         = cell_drv.row;
  assign cell_if.center_type = cell_drv.center_type;
  assign cell_if.south_type  = cell_drv.south_type;
  assign cell_if.west_type   = cell_drv.west_type;
  assign cell_if.east_type   = cell_drv.east_type;
  assign cell_if.north_type  = cell_drv.north_type;
  assign entry_if.ready      = rcv_ready;

  stencil_csr_pattern_builder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cell_i      (cell_if),
    .entry_o     (entry_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #ClkHalf clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow registers and entry counter of the predictor (reset values)
  // --------------------------------------------------------------------------
  int unsigned     m_aw     = MaxWidth;
  int unsigned     m_ah     = MaxHeight;
  int unsigned     m_fw     = MaxWidth;
  bit              m_per    = 1'b0;
  logic [TypeW-1:0] m_solid = '0;
  logic [TypeW-1:0] m_bnd   = '0;
  logic [TypeW-1:0] m_fluid = '0;
  logic [CntW-1:0] nz_count = '0;

  cell_req_t  pending_cells[$];     // requests not yet offered
  row_entry_t expected_entries[$];  // CSR entries still to come, oldest first
  row_entry_t row_scratch[$];       // entries of the cell being predicted
  row_entry_t want_entry;

  bit cell_taken  = 1'b0;           // set by the monitor when the offered request went in
  bit quiet_phase = 1'b0;           // no stalls on either side
  int send_idle   = 0;
  int recv_idle   = 0;
  int error_count = 0;
  int cells_sent  = 0;
  int results_seen = 0;
  int phases_run  = 0;
  int cycle_count = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [LinW-1:0] lin_index(int unsigned c, int unsigned r);
    return LinW'(c + r * m_fw);
  endfunction

  // one nonzero, numbered by the running counter
  function automatic void append_nz(dir_e d, logic [LinW-1:0] rowi, logic [LinW-1:0] coli);
    row_scratch.push_back('{1'b1, d, rowi, coli, nz_count, '0, 1'b0});
    nz_count = nz_count + 1'b1;
  endfunction

  function automatic void build_row_entries(cell_req_t req);
    int unsigned     c;
    int unsigned     r;
    int unsigned     ec;
    int unsigned     wc;
    logic [LinW-1:0] rowi;
    logic [TypeW-1:0] acc;
    bit cb, s_ok, n_ok, w_ok, e_ok;
    c    = req.col;
    r    = req.row;
    rowi = lin_index(c, r);
    acc  = m_bnd | m_fluid;
    row_scratch.delete();
    if (req.first_cell) nz_count = '0;

    if (c < m_aw && r < m_ah) begin
      if ((req.center_type & m_solid) != 0) begin
        // solid: only a solid boundary keeps its diagonal
        if ((req.center_type & m_bnd) != 0) append_nz(DIR_C, rowi, rowi);
      end else begin
        // boundary-flagged center: all neighbor tests fail
        cb   = (req.center_type & m_bnd) != 0;
        ec   = (c + 1 == m_aw) ? 0 : c + 1;
        wc   = (c == 0) ? m_aw - 1 : c - 1;
        s_ok = !cb && r >= 1 && (req.south_type & acc) != 0;
        n_ok = !cb && r + 1 < m_ah && (req.north_type & acc) != 0;
        w_ok = !cb && (m_per || c >= 1) && (req.west_type & acc) != 0;
        e_ok = !cb && (m_per || c + 1 < m_aw) && (req.east_type & acc) != 0;

        if (s_ok) append_nz(DIR_S, rowi, lin_index(c, r - 1));
        if (m_per && c == 0) begin
          // wrapped west is the highest column, so it goes after east
          append_nz(DIR_C, rowi, rowi);
          if (e_ok) append_nz(DIR_E, rowi, lin_index(ec, r));
          if (w_ok) append_nz(DIR_W, rowi, lin_index(wc, r));
        end else if (m_per && c + 1 == m_aw) begin
          // wrapped east is column 0, so it comes before west and center
          if (e_ok) append_nz(DIR_E, rowi, lin_index(ec, r));
          if (w_ok) append_nz(DIR_W, rowi, lin_index(wc, r));
          append_nz(DIR_C, rowi, rowi);
        end else begin
          if (w_ok) append_nz(DIR_W, rowi, lin_index(wc, r));
          append_nz(DIR_C, rowi, rowi);
          if (e_ok) append_nz(DIR_E, rowi, lin_index(ec, r));
        end
        if (n_ok) append_nz(DIR_N, rowi, lin_index(c, r + 1));
      end
    end

    // a cell with no nonzeros still reports its row end pointer
    if (row_scratch.size() == 0) row_scratch.push_back('{1'b0, DIR_S, rowi, '0, '0, '0, 1'b0});
    foreach (row_scratch[i]) begin
      row_scratch[i].row_end_pointer = nz_count;
      row_scratch[i].last            = (i == row_scratch.size() - 1);
      expected_entries.push_back(row_scratch[i]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_cell(bit first, int unsigned col, int unsigned row,
                                     logic [TypeW-1:0] ct, logic [TypeW-1:0] st,
                                     logic [TypeW-1:0] wt, logic [TypeW-1:0] et,
                                     logic [TypeW-1:0] nt);
    pending_cells.push_back('{first, ColW'(col), RowW'(row), ct, st, wt, et, nt});
  endfunction

  // types biased toward the classes the current masks define
  function automatic logic [TypeW-1:0] pick_type();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return m_solid;
      2:       return m_bnd;
      3:       return m_fluid;
      4:       return m_solid | m_bnd;
      5:       return m_fluid | m_bnd;
      6:       return TyAll;
      default: return TypeW'($urandom());
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CfgDataW'($urandom());
      default: return CfgDataW'(1) << $urandom_range(0, CfgDataW - 1);
    endcase
  endfunction

  // mostly small sizes; sometimes the maximum or a larger value that may saturate
  function automatic logic [CfgDataW-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return 16'd1;
      1:       return 16'd2;
      2, 3:    return CfgDataW'($urandom_range(3, 9));
      4:       return CfgDataW'(MaxWidth);
      default: return CfgDataW'($urandom_range(10, 2047));
    endcase
  endfunction

  // register write; shadow copy follows at once since the block is idle
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    logic [CfgW-1:0] size_val;
    size_val = data[CfgW-1:0];
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_ACTIVE_WIDTH:  m_aw    = (size_val > MaxWidth)  ? MaxWidth  : size_val;
      CFG_ACTIVE_HEIGHT: m_ah    = (size_val > MaxHeight) ? MaxHeight : size_val;
      CFG_FULL_WIDTH:    m_fw    = (size_val > MaxWidth)  ? MaxWidth  : size_val;
      CFG_PERIODIC:      m_per   = data[0];
      CFG_SOLID_MASK:    m_solid = data[TypeW-1:0];
      CFG_BOUNDARY_MASK: m_bnd   = data[TypeW-1:0];
      CFG_FLUID_MASK:    m_fluid = data[TypeW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // all requests in, all entries out, then the settle wait; counts the phase
  task automatic wait_idle();
    while (pending_cells.size() != 0 || drv_valid || expected_entries.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    phases_run++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= MaxReports)
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Cell driver: offers the oldest pending request at the falling edge and
  // holds it until the monitor sees it taken. Random idle bursts in between.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (drv_valid && !cell_taken) begin
        // request still waiting for ready
      end else begin
        cell_taken = 1'b0;
        if (send_idle > 0) begin
          send_idle--;
          drv_valid <= 1'b0;
        end else if (!quiet_phase && pending_cells.size() != 0 && $urandom_range(0, 5) == 0) begin
          send_idle = $urandom_range(0, 6);
          drv_valid <= 1'b0;
        end else if (pending_cells.size() != 0) begin
          cell_drv  <= pending_cells.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_idle > 0) begin
        recv_idle--;
        rcv_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        recv_idle = $urandom_range(0, 6);
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks entries first, then predicts for a request taken at this
  // edge, so a same-edge request never sits ahead of older entries.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (entry_if.valid && entry_if.ready) begin
        results_seen++;
        if (expected_entries.size() == 0) begin
          report_mismatch("entry with nothing expected, row_index", entry_if.row_index, '0);
        end else begin
          want_entry = expected_entries.pop_front();
          if (entry_if.entry_valid !== want_entry.entry_valid)
            report_mismatch("entry_valid", entry_if.entry_valid, want_entry.entry_valid);
          if (entry_if.direction !== want_entry.direction)
            report_mismatch("direction", entry_if.direction, want_entry.direction);
          if (entry_if.row_index !== want_entry.row_index)
            report_mismatch("row_index", entry_if.row_index, want_entry.row_index);
          if (entry_if.col_index !== want_entry.col_index)
            report_mismatch("col_index", entry_if.col_index, want_entry.col_index);
          if (entry_if.entry_index !== want_entry.entry_index)
            report_mismatch("entry_index", entry_if.entry_index, want_entry.entry_index);
          if (entry_if.row_end_pointer !== want_entry.row_end_pointer)
            report_mismatch("row_end_pointer", entry_if.row_end_pointer,
                            want_entry.row_end_pointer);
          if (entry_if.last !== want_entry.last)
            report_mismatch("last", entry_if.last, want_entry.last);
        end
      end
      if (cell_if.valid && cell_if.ready) begin
        build_row_entries(cell_drv);
        cell_taken = 1'b1;
        cells_sent++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d entries outstanding", cycle_count,
               expected_entries.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int gw;
    int gh;
    int pos;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Small 4x3 grid with a wider row pitch, one bit per node class.
    cfg_write(CFG_ACTIVE_WIDTH, 16'd4);
    cfg_write(CFG_ACTIVE_HEIGHT, 16'd3);
    cfg_write(CFG_FULL_WIDTH, 16'd5);
    cfg_write(CFG_PERIODIC, 16'd0);
    cfg_write(CFG_SOLID_MASK, TySolid);
    cfg_write(CFG_BOUNDARY_MASK, TyBnd);
    cfg_write(CFG_FLUID_MASK, TyFluid);
    cfg_write(CfgUnusedIdx, 16'hFFFF);
    queue_cell(1, 0, 0, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid); // lower-left corner
    queue_cell(0, 1, 1, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid); // full stencil
    queue_cell(0, 3, 2, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid); // upper-right corner
    queue_cell(0, 1, 1, TySolid, TyFluid, TyFluid, TyFluid, TyFluid); // interior solid
    queue_cell(0, 2, 1, TySolidBnd, TyFluid, TyFluid, TyFluid, TyFluid); // solid boundary
    queue_cell(0, 2, 1, TyBnd, TyFluid, TyFluid, TyFluid, TyFluid);   // boundary, not solid
    queue_cell(0, 1, 1, TyFluid, 16'h0000, TySolid, TyBnd, TyAll);    // mixed neighbors
    queue_cell(0, 4, 0, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid); // column outside
    queue_cell(0, 0, 3, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid); // row outside
    queue_cell(1, 1, 1, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid); // counter restart
    wait_idle();

    // Largest grid, reached through saturating writes; far corner cells.
    cfg_write(CFG_ACTIVE_WIDTH, 16'hFFFF);
    cfg_write(CFG_ACTIVE_HEIGHT, 16'd1024);
    cfg_write(CFG_FULL_WIDTH, 16'h07FF);
    cfg_write(CFG_SOLID_MASK, 16'h0000);
    queue_cell(0, 1023, 1023, TyFluid, TyAll, TyAll, TyAll, TyAll);
    queue_cell(0, 1023, 1022, TyFluid, TyAll, TyAll, TyAll, TyAll);
    queue_cell(1, 1023, 0, TyAll, TyAll, TyAll, TyAll, TyAll);
    queue_cell(0, 0, 0, TyFluid, TyAll, TyAll, TyAll, TyAll);
    wait_idle();

    // Periodic wrap on a 4-wide grid: both edge orderings and the middle.
    cfg_write(CFG_ACTIVE_WIDTH, 16'd4);
    cfg_write(CFG_ACTIVE_HEIGHT, 16'd3);
    cfg_write(CFG_FULL_WIDTH, 16'd4);
    cfg_write(CFG_PERIODIC, 16'd1);
    cfg_write(CFG_SOLID_MASK, TySolid);
    queue_cell(1, 0, 1, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid);
    queue_cell(0, 3, 1, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid);
    queue_cell(0, 1, 1, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid);
    queue_cell(0, 3, 0, TyFluid, TyFluid, 16'h0000, TyBnd, TyFluid);
    wait_idle();

    // One column, periodic: column 0 is also the last column.
    cfg_write(CFG_ACTIVE_WIDTH, 16'd1);
    queue_cell(0, 0, 1, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid);
    queue_cell(0, 0, 0, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid);
    wait_idle();

    // Zero active width, then zero active height: everything is outside.
    cfg_write(CFG_ACTIVE_WIDTH, 16'd0);
    queue_cell(1, 0, 0, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid);
    wait_idle();
    cfg_write(CFG_ACTIVE_WIDTH, 16'd3);
    cfg_write(CFG_ACTIVE_HEIGHT, 16'd0);
    queue_cell(0, 0, 0, TyFluid, TyFluid, TyFluid, TyFluid, TyFluid);
    wait_idle();

    // Random phases: raster sweeps of a small grid (sometimes one column or
    // row past the active edge) with random types, plus random noise cells.
    for (int p = 0; p < RandPhases; p++) begin
      quiet_phase = (p == RandPhases - 1);
      cfg_write(CFG_ACTIVE_WIDTH, pick_size());
      cfg_write(CFG_ACTIVE_HEIGHT, pick_size());
      cfg_write(CFG_FULL_WIDTH, pick_size());
      cfg_write(CFG_PERIODIC, CfgDataW'($urandom_range(0, 1)));
      cfg_write(CFG_SOLID_MASK, pick_mask());
      cfg_write(CFG_BOUNDARY_MASK, pick_mask());
      cfg_write(CFG_FLUID_MASK, pick_mask());
      gw = (m_aw > 10) ? $urandom_range(2, 8) : m_aw;
      gh = (m_ah > 10) ? $urandom_range(2, 8) : m_ah;
      if ($urandom_range(0, 3) == 0) gw++;
      if ($urandom_range(0, 3) == 0) gh++;
      pos = 0;
      for (int n = 0; n < PhaseCells; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_cell($urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 1023),
                     TypeW'($urandom()), TypeW'($urandom()), TypeW'($urandom()),
                     TypeW'($urandom()), TypeW'($urandom()));
        end else begin
          queue_cell(pos == 0, pos % gw, pos / gw, pick_type(), pick_type(), pick_type(),
                     pick_type(), pick_type());
          pos = (pos + 1) % (gw * gh);
        end
      end
      wait_idle();
    end

    $display("run covered %0d cell requests and %0d CSR entries over %0d register settings",
             cells_sent, results_seen, phases_run);
    $display("directed edges, node classes, wrap orders and zero sizes, then random sweeps");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
